[sv/table_linear_interpolator_core_macros.svh]
// Assertion helpers for the interpolator core.
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tli_pkg.sv]
package tli_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int VAL_W          = 32;
	localparam int PROD_W         = 2 * VAL_W;
	localparam int CFG_W          = 7;
	localparam int PIDX_W         = 6;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMP_LAST,
		S_CMP_FIRST,
		S_SCAN,
		S_RD_A,
		S_RD_B,
		S_MUL,
		S_DIV,
		S_WAIT,
		S_RESULT
	} tli_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/tli_table.sv]
module tli_table #(
	parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
	parameter int AW         = $clog2(MAX_POINTS)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [tli_pkg::VAL_W-1:0] wr_x,
	input  logic [tli_pkg::VAL_W-1:0] wr_y,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [tli_pkg::VAL_W-1:0] x_rd,
	output logic [tli_pkg::VAL_W-1:0] y_rd
);
	import tli_pkg::*;

	logic [VAL_W-1:0] x_mem [MAX_POINTS];
	logic [VAL_W-1:0] y_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			x_rd <= x_mem[rd_addr];
			y_rd <= y_mem[rd_addr];
		end
	end

endmodule

[sv/tli_div.sv]
module tli_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tli_pkg::PROD_W-1:0] dividend,
	input  logic [tli_pkg::VAL_W-1:0]  divisor,
	output tli_pkg::div_stat_t         stat,
	output logic [tli_pkg::PROD_W-1:0] quotient
);
	import tli_pkg::*;

	localparam int CW = $clog2(PROD_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  dvs_q;
	logic [PROD_W-1:0] quo_q;
	logic [VAL_W:0]    trial;
	logic              fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(PROD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? VAL_W'(trial - {1'b0, dvs_q}) : trial[VAL_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[sv/table_linear_interpolator_core.sv]
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  kind, point_index, point_x, point_y, query_x
// out       source     out_valid/out_stall value, zero_span
// cfg       sink       cfg_valid/cfg_ready cfg_data (points_in_use)
//
// A point transfer writes both tables at once.
// A query runs a one-read-per-cycle scan of the x table over the n points in
// use, then a 64-step restoring divider.
// in_stall is high from query acceptance until its result is loaded into the
// output register; a result waiting on out_stall does not block the next item
// unless another query result is ready behind it.
// arst_n clears control state and sets points_in_use to 2; tables are not cleared.
module table_linear_interpolator_core #(
	parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [tli_pkg::PIDX_W-1:0]        point_index,
	input  logic signed [tli_pkg::VAL_W-1:0]  point_x,
	input  logic signed [tli_pkg::VAL_W-1:0]  point_y,
	input  logic signed [tli_pkg::VAL_W-1:0]  query_x,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tli_pkg::VAL_W-1:0]  value,
	output logic                              zero_span,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tli_pkg::CFG_W-1:0]         cfg_data
);
	import tli_pkg::*;

	`include "table_linear_interpolator_core_macros.svh"

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int RW    = VAL_W + 4;
	localparam logic signed [RW-1:0] R_MAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [RW-1:0] R_MIN = 36'shF_8000_0000;
	localparam logic [PROD_W-1:0] QUO_LIMIT = 64'h4_0000_0000;

	tli_state_t state_q, state_d;

	logic [CFG_W-1:0]        cfg_q;
	logic [CNT_W-1:0]        n_w;
	logic [CNT_W-1:0]        n_q;
	logic [AW-1:0]           idx_q;
	logic signed [VAL_W-1:0] q_q;
	logic signed [VAL_W-1:0] prev_q;
	logic signed [VAL_W-1:0] xa_q;
	logic signed [VAL_W-1:0] ya_q;
	logic [VAL_W-1:0]        dy_mag_q;
	logic [VAL_W-1:0]        dq_mag_q;
	logic [VAL_W-1:0]        dx_mag_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    res_zero_q;
	logic                    out_valid_q;

	logic                    in_xfer;
	logic                    q_xfer;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [VAL_W-1:0]        x_rd;
	logic [VAL_W-1:0]        y_rd;
	logic signed [VAL_W-1:0] x_s;
	logic                    scan_hit;
	logic                    scan_last;
	logic                    out_free;

	logic signed [VAL_W:0]   dx_w;
	logic signed [VAL_W:0]   dy_w;
	logic signed [VAL_W:0]   dq_w;
	logic [VAL_W:0]          dx_abs;
	logic [VAL_W:0]          dy_abs;
	logic [VAL_W:0]          dq_abs;

	logic                    div_start;
	div_stat_t               div_stat;
	logic [PROD_W-1:0]       quo;
	logic signed [RW-1:0]    sum_w;
	logic signed [VAL_W-1:0] fin_w;

	// ---------------- handshakes ----------------
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;
	assign q_xfer    = in_xfer && (kind == KIND_QUERY);
	assign out_free  = !out_valid_q || !out_stall;

	// point writes go straight to the tables; slots past the depth are dropped
	assign wr_en   = in_xfer && (kind == KIND_POINT) && (32'(point_index) < MAX_POINTS);
	assign wr_addr = AW'(point_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// point count clamped to [2, MAX_POINTS]
	always_comb begin
		if (32'(cfg_q) < 2) begin
			n_w = CNT_W'(2);
		end else if (32'(cfg_q) > MAX_POINTS) begin
			n_w = CNT_W'(MAX_POINTS);
		end else begin
			n_w = CNT_W'(cfg_q);
		end
	end

	tli_table #(
		.MAX_POINTS(MAX_POINTS),
		.AW        (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_x   (point_x),
		.wr_y   (point_y),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.x_rd   (x_rd),
		.y_rd   (y_rd)
	);

	assign x_s       = $signed(x_rd);
	// x_rd holds x[idx+1] while scanning
	assign scan_hit  = (prev_q <= q_q) && (q_q <= x_s);
	assign scan_last = CNT_W'(idx_q) == (n_q - CNT_W'(2));

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_xfer) begin
					state_d = S_CMP_LAST;
				end
			end
			S_CMP_LAST: begin
				state_d = (q_q > x_s) ? S_RD_A : S_CMP_FIRST;
			end
			S_CMP_FIRST: begin
				state_d = (q_q < x_s) ? S_RD_A : S_SCAN;
			end
			S_SCAN: begin
				if (scan_hit || scan_last) begin
					state_d = S_RD_A;
				end
			end
			S_RD_A: begin
				state_d = S_RD_B;
			end
			S_RD_B: begin
				state_d = (dx_w == '0) ? S_RESULT : S_MUL;
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (div_stat.done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				rd_en    = q_xfer;
				rd_addr  = AW'(n_w - CNT_W'(1));
			end
			S_CMP_LAST: begin
				rd_en   = 1'b1;
				rd_addr = (q_q > x_s) ? AW'(n_q - CNT_W'(2)) : '0;
			end
			S_CMP_FIRST: begin
				rd_en   = 1'b1;
				rd_addr = (q_q < x_s) ? '0 : AW'(1);
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = (scan_hit || scan_last) ? idx_q : idx_q + AW'(2);
			end
			S_RD_A: begin
				rd_en   = 1'b1;
				rd_addr = idx_q + AW'(1);
			end
			S_DIV: begin
				div_start = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- datapath ----------------
	assign dx_w   = {x_s[VAL_W-1], x_s} - {xa_q[VAL_W-1], xa_q};
	assign dy_w   = $signed({y_rd[VAL_W-1], y_rd}) - {ya_q[VAL_W-1], ya_q};
	assign dq_w   = {q_q[VAL_W-1], q_q} - {xa_q[VAL_W-1], xa_q};
	assign dx_abs = dx_w[VAL_W] ? -dx_w : dx_w;
	assign dy_abs = dy_w[VAL_W] ? -dy_w : dy_w;
	assign dq_abs = dq_w[VAL_W] ? -dq_w : dq_w;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_xfer) begin
					q_q <= query_x;
					n_q <= n_w;
				end
			end
			S_CMP_LAST: begin
				idx_q <= (q_q > x_s) ? AW'(n_q - CNT_W'(2)) : '0;
			end
			S_CMP_FIRST: begin
				idx_q  <= '0;
				prev_q <= x_s;
			end
			S_SCAN: begin
				if (!scan_hit && !scan_last) begin
					prev_q <= x_s;
					idx_q  <= idx_q + AW'(1);
				end
			end
			S_RD_A: begin
				xa_q <= x_s;
				ya_q <= $signed(y_rd);
			end
			S_RD_B: begin
				dx_mag_q    <= dx_abs[VAL_W-1:0];
				dy_mag_q    <= dy_abs[VAL_W-1:0];
				dq_mag_q    <= dq_abs[VAL_W-1:0];
				neg_q       <= (dy_w[VAL_W] ^ dq_w[VAL_W]) ^ dx_w[VAL_W];
				res_value_q <= '0;
				res_zero_q  <= (dx_w == '0);
			end
			S_MUL: begin
				prod_q <= PROD_W'(dy_mag_q) * PROD_W'(dq_mag_q);
			end
			S_WAIT: begin
				if (div_stat.done) begin
					res_value_q <= fin_w;
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	tli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q),
		.divisor (dx_mag_q),
		.stat    (div_stat),
		.quotient(quo)
	);

	// ya +/- quotient, saturated to Q16.16
	assign sum_w = neg_q ? ({{(RW-VAL_W){ya_q[VAL_W-1]}}, ya_q} - $signed({1'b0, quo[RW-2:0]}))
	                     : ({{(RW-VAL_W){ya_q[VAL_W-1]}}, ya_q} + $signed({1'b0, quo[RW-2:0]}));

	always_comb begin
		if (quo > QUO_LIMIT) begin
			fin_w = neg_q ? R_MIN[VAL_W-1:0] : R_MAX[VAL_W-1:0];
		end else if (sum_w > R_MAX) begin
			fin_w = R_MAX[VAL_W-1:0];
		end else if (sum_w < R_MIN) begin
			fin_w = R_MIN[VAL_W-1:0];
		end else begin
			fin_w = sum_w[VAL_W-1:0];
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			value     <= res_value_q;
			zero_span <= res_zero_q;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- checks ----------------
	`TLI_ASSERT_NOW(a_zero_span_value, out_valid && zero_span, value == '0, "zero span result not 0")
	`TLI_ASSERT_NEXT(a_query_taken, q_xfer, state_q == S_CMP_LAST, "query transfer dropped")
	`TLI_ASSERT_NOW(a_div_idle_start, div_start, !div_stat.busy, "divider restarted while busy")
	`TLI_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, CNT_W'(idx_q) <= n_q - CNT_W'(2), "scan past last segment")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

// Interpolator bench: point transfers load the curve tables, query transfers are
// predicted at acceptance and checked in order against the output channel.
// Stimulus is built per phase: one points_in_use setting, a fresh curve, then a
// mix of queries, table noise and curve reloads. Both channels idle in random bursts.
module tb_top;
	import tli_pkg::*;

	localparam int NPTS          = MAX_POINTS_DEF;
	localparam int SETTLE_CYCLES = 200;   // covers the longest query at 64 points
	localparam int WATCHDOG_MAX  = 4000;  // quiet cycles before giving up
	localparam int HOLD_CYCLES   = 500;   // long receiver hold-off, fills the block
	localparam int PHASES        = 14;
	localparam int FILL_ITEMS    = 21;    // items per phase after the curve load

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	// one input transfer as the bench sees it
	typedef struct packed {
		logic                    kind;
		logic [PIDX_W-1:0]       slot;
		logic signed [VAL_W-1:0] px;
		logic signed [VAL_W-1:0] py;
		logic signed [VAL_W-1:0] qx;
	} lerp_item_t;

	// one expected output transfer
	typedef struct packed {
		logic signed [VAL_W-1:0] y;
		logic                    flat;
	} lerp_out_t;

	typedef enum int {
		CURVE_RISING,      // ascending x, random y
		CURVE_FLAT_STEPS,  // ascending x with repeated x, gives zero spans
		CURVE_SCRAMBLED    // x in random order
	} curve_shape_t;

	// ---------------------------------------------------------------- DUT ports
	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    kind        = KIND_POINT;
	logic [PIDX_W-1:0]       point_index = '0;
	logic signed [VAL_W-1:0] point_x     = '0;
	logic signed [VAL_W-1:0] point_y     = '0;
	logic signed [VAL_W-1:0] query_x     = '0;
	logic                    out_stall   = 1'b0;
	logic                    cfg_valid   = 1'b0;
	logic [CFG_W-1:0]        cfg_data    = '0;
	logic                    in_stall;
	logic                    out_valid;
	logic signed [VAL_W-1:0] value;
	logic                    zero_span;
	logic                    cfg_ready;

	table_linear_interpolator_core #(
		.MAX_POINTS(NPTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.point_index(point_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.query_x    (query_x),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.zero_span  (zero_span),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------ bench state
	lerp_item_t items_to_send [$];     // built by the stimulus process
	lerp_out_t  expected_values [$];   // predicted at query acceptance
	int         queued_cnt   = 0;
	int         accepted_cnt = 0;
	int         fail_cnt     = 0;
	int         quiet_cycles = 0;

	// predictor copy of the block state, updated at transfer time
	logic signed [VAL_W-1:0] pred_x_tab [NPTS];
	logic signed [VAL_W-1:0] pred_y_tab [NPTS];
	logic [CFG_W-1:0]        pred_points = CFG_RESET;

	// generator view of the table, updated as items are queued
	logic signed [VAL_W-1:0] gen_x_tab [NPTS];
	logic signed [VAL_W-1:0] curve_x [NPTS];
	int                      gen_points = 2;

	// idling control for the two channel processes
	bit  idle_on   = 1'b1;
	int  hold_req  = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	int  feed_gap  = 0;
	logic in_fire_q = 1'b0;

	// register value 0/1 and 65..127 are clamped into the legal point count
	function automatic int clamp_points(input logic [CFG_W-1:0] c);
		if (c < 2)
			return 2;
		if (c > NPTS)
			return NPTS;
		return int'(c);
	endfunction

	// y at qx from the predictor tables, saturated Q16.16
	function automatic lerp_out_t lerp_predict(input logic signed [VAL_W-1:0] qx);
		int                  n, seg, i;
		bit                  hit, neg;
		longint              q, xa, xb, ya, yb, dx, dy, dq, r;
		longint unsigned     mdx, mdy, mdq, prod, quo;
		lerp_out_t           res;
		n = clamp_points(pred_points);
		q = qx;
		seg = n - 2;
		// above the last point wins even on a descending table
		if (q > longint'(pred_x_tab[n - 1]))
			seg = n - 2;
		else if (q < longint'(pred_x_tab[0]))
			seg = 0;
		else begin
			// first enclosing segment; none found falls back to the last one
			hit = 1'b0;
			for (i = 0; i < n - 1; i++)
				if (!hit && longint'(pred_x_tab[i]) <= q && q <= longint'(pred_x_tab[i + 1])) begin
					seg = i;
					hit = 1'b1;
				end
		end
		xa = pred_x_tab[seg];
		xb = pred_x_tab[seg + 1];
		ya = pred_y_tab[seg];
		yb = pred_y_tab[seg + 1];
		dx = xb - xa;
		if (dx == 0) begin
			res.y = '0;
			res.flat = 1'b1;
			return res;
		end
		dy = yb - ya;
		dq = q - xa;
		neg = ((dy < 0) != (dq < 0)) != (dx < 0);
		mdx = (dx < 0) ? -dx : dx;
		mdy = (dy < 0) ? -dy : dy;
		mdq = (dq < 0) ? -dq : dq;
		// both magnitudes are below 2^32, so the product fits 64 bits
		prod = mdy * mdq;
		quo = prod / mdx;    // truncates toward zero on the magnitude
		if (quo > (64'd1 << 34))
			r = neg ? SAT_LO : SAT_HI;
		else begin
			r = neg ? ya - longint'(quo) : ya + longint'(quo);
			if (r > SAT_HI)
				r = SAT_HI;
			if (r < SAT_LO)
				r = SAT_LO;
		end
		res.y = r[VAL_W-1:0];
		res.flat = 1'b0;
		return res;
	endfunction

	// ------------------------------------------------------- stimulus helpers
	task automatic push_point(input logic [PIDX_W-1:0] slot, input logic signed [VAL_W-1:0] x,
		input logic signed [VAL_W-1:0] y);
		lerp_item_t it;
		it.kind = KIND_POINT;
		it.slot = slot;
		it.px = x;
		it.py = y;
		it.qx = $signed($urandom);   // don't-care field, keep it moving
		items_to_send.push_back(it);
		gen_x_tab[slot] = x;
		queued_cnt++;
	endtask

	task automatic push_query(input logic signed [VAL_W-1:0] x);
		lerp_item_t it;
		it.kind = KIND_QUERY;
		it.slot = PIDX_W'($urandom);
		it.px = $signed($urandom);
		it.py = $signed($urandom);
		it.qx = x;
		items_to_send.push_back(it);
		queued_cnt++;
	endtask

	// writes slots 0..cnt-1, so no query ever touches an unwritten entry
	task automatic load_curve(input int cnt, input curve_shape_t shape);
		int                      i, j, xsh, ysh;
		logic signed [VAL_W-1:0] key;
		xsh = $urandom_range(0, 31);   // scale: full range down to 0/-1
		ysh = $urandom_range(0, 31);
		for (i = 0; i < cnt; i++)
			curve_x[i] = $signed($urandom) >>> xsh;
		if (shape != CURVE_SCRAMBLED) begin
			for (i = 1; i < cnt; i++) begin
				key = curve_x[i];
				j = i - 1;
				while (j >= 0 && curve_x[j] > key) begin
					curve_x[j + 1] = curve_x[j];
					j--;
				end
				curve_x[j + 1] = key;
			end
		end
		if (shape == CURVE_FLAT_STEPS)
			for (i = 1; i < cnt; i++)
				if ($urandom_range(0, 2) == 0)
					curve_x[i] = curve_x[i - 1];
		for (i = 0; i < cnt; i++)
			push_point(PIDX_W'(i), curve_x[i], $signed($urandom) >>> ysh);
	endtask

	// query x aimed at the points, segment interiors, both outer regions or anywhere
	function automatic logic signed [VAL_W-1:0] pick_query_x();
		int     n, i;
		longint a, b, r;
		n = gen_points;
		i = $urandom_range(0, n - 2);
		a = gen_x_tab[i];
		b = gen_x_tab[i + 1];
		case ($urandom_range(0, 6))
			0: begin
				r = a;
			end
			1, 2: begin
				r = a + ((b - a) * longint'($urandom_range(0, 1024))) / 1024;
			end
			3: begin
				r = longint'(gen_x_tab[0]) - longint'($urandom_range(1, 65536)) *
					($urandom_range(0, 1) ? 64'sd1 : 64'sd65536);
			end
			4: begin
				r = longint'(gen_x_tab[n - 1]) + longint'($urandom_range(1, 65536)) *
					($urandom_range(0, 1) ? 64'sd1 : 64'sd65536);
			end
			default: begin
				r = longint'($signed($urandom));
			end
		endcase
		if (r > SAT_HI)
			r = SAT_HI;
		if (r < SAT_LO)
			r = SAT_LO;
		return r[VAL_W-1:0];
	endfunction

	// register write; only called with the block idle
	task automatic write_points_reg(input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		pred_points = val;
		gen_points = clamp_points(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain: everything sent, every result back, then let a trailing point
	// transfer or search finish inside the block
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || expected_values.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------- input driver
	// A new transfer is offered only once the previous one went through, so
	// valid never looks at stall and a held payload stays put.
	always @(negedge clk) begin : feed
		lerp_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire_q) begin
			if (feed_gap > 0) begin
				in_valid <= 1'b0;
				feed_gap--;
			end else if (items_to_send.size() > 0) begin
				nxt = items_to_send.pop_front();
				kind <= nxt.kind;
				point_index <= nxt.slot;
				point_x <= nxt.px;
				point_y <= nxt.py;
				query_x <= nxt.qx;
				in_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0)
					feed_gap = $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------- output stall
	// hold_req bumps start one long hold-off; otherwise short random bursts
	always @(negedge clk) begin : drain
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 9);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------- monitor + scoring
	always @(posedge clk) begin : score
		lerp_out_t want;
		if (!arst_n) begin
			in_fire_q <= 1'b0;
		end else begin
			in_fire_q <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$display("%0t: result with nothing pending: value %h zero_span %b",
						$time, value, zero_span);
					fail_cnt++;
				end else begin
					want = expected_values.pop_front();
					if (value !== want.y) begin
						$display("%0t: value mismatch: expected %h, actual %h",
							$time, want.y, value);
						fail_cnt++;
					end
					if (zero_span !== want.flat) begin
						$display("%0t: zero_span mismatch: expected %b, actual %b",
							$time, want.flat, zero_span);
						fail_cnt++;
					end
				end
			end
			// input transfer: update tables or predict the query
			if (in_valid && !in_stall) begin
				accepted_cnt++;
				if (kind == KIND_POINT) begin
					pred_x_tab[point_index] = point_x;
					pred_y_tab[point_index] = point_y;
				end else begin
					expected_values.push_back(lerp_predict(query_x));
				end
			end
		end
	end

	// ------------------------------------------------------------- watchdog
	always @(posedge clk) begin : watchdog
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready))) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	// ------------------------------------------------------------- sequence
	initial begin : run
		int           ph, k, r;
		int           setting;
		curve_shape_t shape;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed, reset point count of 2
		push_point(0, 32'sh0000_0000, 32'sh0000_0000);
		push_point(1, 32'sh0001_0000, 32'sh0002_0000);   // slope 2
		push_query(32'sh0000_0000);                      // on the first point
		push_query(32'sh0001_0000);                      // on the last point
		push_query(32'sh0000_8000);                      // mid segment
		push_query(32'shFFFF_0000);                      // below: extrapolate down
		push_query(32'sh8000_0000);                      // far below: saturate low
		push_query(32'sh7FFF_FFFF);                      // far above: saturate high
		push_point(1, 32'sh0000_0000, 32'sh7FFF_FFFF);   // zero-width segment
		push_query(32'sh1234_5678);
		push_point(0, 32'sh8000_0000, 32'sh8000_0000);   // full-range diagonal
		push_point(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		push_query(32'sh8000_0000);
		push_query(32'sh7FFF_FFFF);
		push_query(32'sh0000_0000);
		push_query(32'shFFFF_FFFF);
		push_point(0, 32'sh0000_0000, 32'sh8000_0000);   // steepest slope
		push_point(1, 32'sh0000_0001, 32'sh7FFF_FFFF);
		push_query(32'sh7FFF_FFFF);                      // quotient overflow, high
		push_query(32'sh8000_0000);                      // quotient overflow, low
		push_point(0, 32'sh7FFF_FFFF, 32'sh1234_5678);   // descending pair
		push_point(1, 32'sh8000_0000, 32'shEDCB_A988);
		push_query(32'sh0000_0000);                      // above x(n-1) and below x(0)
		push_point(PIDX_W'(NPTS - 1), 32'shFFFF_FFFF, 32'sh0000_0000);  // top slot, unused
		push_query(32'sh7FFF_FFFF);
		wait_idle();

		// random phases; clamp cases and both extremes come first
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: setting = NPTS;
				1: setting = 0;
				2: setting = 127;
				3: setting = 1;
				4: setting = NPTS + 1;
				5: setting = 3;
				default: setting = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
					$urandom_range(2, 8);
			endcase
			// some phases run flat out; the last ones never idle
			idle_on = (ph < PHASES - 2) && (ph % 4 != 2);
			write_points_reg(CFG_W'(setting));
			if (ph == 5)
				hold_req++;   // long output hold while queries keep coming
			load_curve(gen_points, CURVE_RISING);
			for (k = 0; k < FILL_ITEMS; k++) begin
				r = $urandom_range(0, 19);
				if (r < 15) begin
					push_query(pick_query_x());
				end else if (r < 18) begin
					// table noise: any slot, any value, may break the order
					push_point(PIDX_W'($urandom_range(0, NPTS - 1)), $signed($urandom),
						$signed($urandom));
				end else begin
					r = $urandom_range(0, 9);
					shape = (r < 6) ? CURVE_RISING :
						(r < 8) ? CURVE_FLAT_STEPS : CURVE_SCRAMBLED;
					load_curve(gen_points, shape);
				end
			end
			wait_idle();
		end

		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
